### hdl/cvt_pkg.sv
package cvt_pkg;

  localparam int CFG_FRAC = 9;
  localparam int FIELD_W  = 21;
  localparam int REG_W    = 63;
  localparam int IDX_W    = 2;
  localparam int DATA_W   = 32;

  typedef enum logic [IDX_W-1:0] {
    CFG_CAMERA = 2'd0,
    CFG_UP     = 2'd1,
    CFG_COI    = 2'd2
  } cfg_idx_e;

  typedef struct packed {
    logic [IDX_W-1:0] cfg_index;
    logic [REG_W-1:0] cfg_value;
  } cfg_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] point_x;
    logic signed [DATA_W-1:0] point_y;
    logic signed [DATA_W-1:0] point_z;
    logic signed [DATA_W-1:0] point_w;
  } point_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] view_x;
    logic signed [DATA_W-1:0] view_y;
    logic signed [DATA_W-1:0] view_z;
    logic signed [DATA_W-1:0] view_w;
  } view_t;

endpackage

### hdl/cvt_chan.sv
interface cvt_chan #(
  parameter type T = logic
);
  logic valid;
  logic ready;
  T     data;

  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/camera_view_transform.sv
// An accepted point reaches its view result through the input, product and sum registers.
// Throughput: one point per cycle outside a rebuild; a full output register stalls the whole pipeline.
// A write to the camera, up or COI register rebuilds the matrix with one shared multiplier,
// a bit-serial square root and a bit-serial divider; points are held off meanwhile.
// Reset (rst_ni low, asynchronous) clears the registers and the matrix to zero and
// empties the pipeline; no rebuild follows reset.
module camera_view_transform #(
  parameter int FRAC_BITS = 16
) (
  input  logic    clk_i,
  input  logic    rst_ni,
  cvt_chan.sink   cfg_i,
  cvt_chan.sink   point_i,
  cvt_chan.source view_o
);

  localparam int NUMW = FRAC_BITS + 31;
  localparam int QW   = FRAC_BITS + 2;
  localparam int CNTW = $clog2(NUMW + 1);
  localparam int PW   = 64 - FRAC_BITS;
  localparam int SW   = PW + 2;
  localparam int DW   = cvt_pkg::FIELD_W + 1;

  typedef enum logic [5:0] {
    ST_IDLE  = 6'b000001,
    ST_SQ    = 6'b000010,
    ST_ROOT  = 6'b000100,
    ST_DIV   = 6'b001000,
    ST_CROSS = 6'b010000,
    ST_TRANS = 6'b100000
  } state_e;

  typedef struct packed {
    logic [1:0] r;
    logic [1:0] i;
  } pos_t;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] x);
    if (x > 64'sd2147483647) return 32'sh7FFFFFFF;
    if (x < -64'sd2147483648) return 32'sh80000000;
    return x[31:0];
  endfunction

  function automatic pos_t trans_pos(input logic [3:0] j);
    pos_t p;
    unique case (j)
      4'd0: p = '{2'd0, 2'd0};
      4'd1: p = '{2'd0, 2'd1};
      4'd2: p = '{2'd0, 2'd2};
      4'd3: p = '{2'd1, 2'd0};
      4'd4: p = '{2'd1, 2'd1};
      4'd5: p = '{2'd1, 2'd2};
      4'd6: p = '{2'd2, 2'd0};
      4'd7: p = '{2'd2, 2'd1};
      4'd8: p = '{2'd2, 2'd2};
      default: p = '{2'd0, 2'd0};
    endcase
    return p;
  endfunction

  state_e state_q;
  logic [cvt_pkg::REG_W-1:0] cam_q, up_q, coi_q;
  logic vec_q;
  logic [1:0] comp_q;
  logic [CNTW-1:0] cnt_q;
  logic signed [63:0] acc_q, prod_q;
  logic [61:0] rad_q;
  logic [30:0] sroot_q, len_q;
  logic [33:0] srem_q;
  logic [NUMW-1:0] num_q;
  logic [30:0] drem_q;
  logic [QW-1:0] quo_q;
  logic signed [QW-1:0] nrm_q [2][3];
  logic signed [31:0] u_q [3];
  logic signed [31:0] m_q [12];

  logic signed [cvt_pkg::FIELD_W-1:0] cam_f [3];
  logic signed [DW-1:0] dn [3], dv [3], dsel [3];
  logic signed [31:0] mul_a, mul_b;
  logic [3:0] hj;
  pos_t ip, hp;
  logic signed [31:0] row_e;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      cam_f[i] = cam_q[cvt_pkg::FIELD_W*i +: cvt_pkg::FIELD_W];
      dn[i] = DW'($signed(cam_q[cvt_pkg::FIELD_W*i +: cvt_pkg::FIELD_W]))
            - DW'($signed(coi_q[cvt_pkg::FIELD_W*i +: cvt_pkg::FIELD_W]));
      dv[i] = DW'($signed(up_q[cvt_pkg::FIELD_W*i +: cvt_pkg::FIELD_W]))
            - DW'($signed(cam_q[cvt_pkg::FIELD_W*i +: cvt_pkg::FIELD_W]));
      dsel[i] = vec_q ? dv[i] : dn[i];
    end
  end

  assign hj = cnt_q[3:0] - 4'd1;
  assign ip = trans_pos(cnt_q[3:0]);
  assign hp = trans_pos(hj);

  always_comb begin
    unique case (ip.r)
      2'd0: row_e = u_q[ip.i];
      2'd1: row_e = 32'(nrm_q[1][ip.i]);
      default: row_e = 32'(nrm_q[0][ip.i]);
    endcase
  end

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_q)
      ST_SQ: begin
        if (cnt_q[1:0] != 2'd3) begin
          mul_a = 32'(dsel[cnt_q[1:0]]);
          mul_b = 32'(dsel[cnt_q[1:0]]);
        end
      end
      ST_CROSS: begin
        unique case (cnt_q[2:0])
          3'd0: begin mul_a = 32'(nrm_q[1][1]); mul_b = 32'(nrm_q[0][2]); end
          3'd1: begin mul_a = 32'(nrm_q[1][2]); mul_b = 32'(nrm_q[0][1]); end
          3'd2: begin mul_a = 32'(nrm_q[1][2]); mul_b = 32'(nrm_q[0][0]); end
          3'd3: begin mul_a = 32'(nrm_q[1][0]); mul_b = 32'(nrm_q[0][2]); end
          3'd4: begin mul_a = 32'(nrm_q[1][0]); mul_b = 32'(nrm_q[0][1]); end
          3'd5: begin mul_a = 32'(nrm_q[1][1]); mul_b = 32'(nrm_q[0][0]); end
          default: begin mul_a = '0; mul_b = '0; end
        endcase
      end
      ST_TRANS: begin
        mul_a = row_e;
        mul_b = 32'(cam_f[ip.i]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  logic cfg_fire, cfg_ok;
  logic [33:0] srem2, strial;
  logic [30:0] sroot_n;
  logic [31:0] r2;
  logic ge;
  logic [QW-1:0] qfin;
  logic [20:0] mag;

  assign cfg_i.ready = (state_q == ST_IDLE);
  assign cfg_fire = cfg_i.valid && cfg_i.ready;
  assign cfg_ok = (cfg_i.data.cfg_index == cvt_pkg::CFG_CAMERA)
               || (cfg_i.data.cfg_index == cvt_pkg::CFG_UP)
               || (cfg_i.data.cfg_index == cvt_pkg::CFG_COI);

  assign srem2   = {srem_q[31:0], rad_q[61:60]};
  assign strial  = {1'b0, sroot_q, 2'b01};
  assign sroot_n = (srem2 >= strial) ? {sroot_q[29:0], 1'b1} : {sroot_q[29:0], 1'b0};
  assign r2      = {drem_q, num_q[NUMW-1]};
  assign ge      = r2 >= {1'b0, len_q};
  assign qfin    = {quo_q[QW-2:0], ge};
  assign mag     = dsel[comp_q][DW-1] ? 21'(-dsel[comp_q]) : 21'(dsel[comp_q]);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    logic signed [63:0] xs;
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cam_q   <= '0;
      up_q    <= '0;
      coi_q   <= '0;
      vec_q   <= 1'b0;
      comp_q  <= '0;
      cnt_q   <= '0;
      acc_q   <= '0;
      prod_q  <= '0;
      rad_q   <= '0;
      sroot_q <= '0;
      srem_q  <= '0;
      len_q   <= '0;
      num_q   <= '0;
      drem_q  <= '0;
      quo_q   <= '0;
      for (int k = 0; k < 3; k++) begin
        nrm_q[0][k] <= '0;
        nrm_q[1][k] <= '0;
        u_q[k]      <= '0;
      end
      for (int k = 0; k < 12; k++) m_q[k] <= '0;
    end else begin
      prod_q <= mul_a * mul_b;
      unique case (state_q)
        ST_IDLE: begin
          if (cfg_fire && cfg_ok) begin
            unique case (cvt_pkg::cfg_idx_e'(cfg_i.data.cfg_index))
              cvt_pkg::CFG_CAMERA: cam_q <= cfg_i.data.cfg_value;
              cvt_pkg::CFG_UP:     up_q  <= cfg_i.data.cfg_value;
              default:             coi_q <= cfg_i.data.cfg_value;
            endcase
            state_q <= ST_SQ;
            vec_q   <= 1'b0;
            cnt_q   <= '0;
          end
        end
        ST_SQ: begin
          if (cnt_q == '0) acc_q <= '0;
          else acc_q <= acc_q + prod_q;
          if (cnt_q == CNTW'(3)) begin
            xs       = acc_q + prod_q;
            rad_q   <= {xs[43:0], 18'b0};
            sroot_q <= '0;
            srem_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_ROOT;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_ROOT: begin
          srem_q  <= (srem2 >= strial) ? srem2 - strial : srem2;
          sroot_q <= sroot_n;
          rad_q   <= {rad_q[59:0], 2'b00};
          if (cnt_q == CNTW'(30)) begin
            len_q   <= sroot_n;
            comp_q  <= '0;
            cnt_q   <= '0;
            state_q <= ST_DIV;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_DIV: begin
          if (cnt_q == '0) begin
            num_q  <= (NUMW'(mag) << (FRAC_BITS + cvt_pkg::CFG_FRAC)) + NUMW'(len_q >> 1);
            drem_q <= '0;
            quo_q  <= '0;
            cnt_q  <= cnt_q + 1'b1;
          end else begin
            drem_q <= ge ? 31'(r2 - {1'b0, len_q}) : r2[30:0];
            quo_q  <= qfin;
            num_q  <= {num_q[NUMW-2:0], 1'b0};
            if (cnt_q == CNTW'(NUMW)) begin
              if (len_q == '0) nrm_q[vec_q][comp_q] <= '0;
              else if (dsel[comp_q][DW-1]) nrm_q[vec_q][comp_q] <= -$signed(qfin);
              else nrm_q[vec_q][comp_q] <= $signed(qfin);
              cnt_q <= '0;
              if (comp_q == 2'd2) begin
                comp_q <= '0;
                if (!vec_q) begin
                  vec_q   <= 1'b1;
                  state_q <= ST_SQ;
                end else begin
                  state_q <= ST_CROSS;
                end
              end else begin
                comp_q <= comp_q + 2'd1;
              end
            end else begin
              cnt_q <= cnt_q + 1'b1;
            end
          end
        end
        ST_CROSS: begin
          if (cnt_q != '0) begin
            if (!hj[0]) begin
              acc_q <= prod_q;
            end else begin
              xs = acc_q - prod_q;
              u_q[hj[2:1]] <= sat32((xs + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
            end
          end
          if (cnt_q == CNTW'(6)) begin
            cnt_q   <= '0;
            state_q <= ST_TRANS;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        ST_TRANS: begin
          if (cnt_q != '0) begin
            if (hp.i == 2'd0) begin
              acc_q <= prod_q;
            end else if (hp.i == 2'd1) begin
              acc_q <= acc_q + prod_q;
            end else begin
              xs = -(acc_q + prod_q);
              m_q[{hp.r, 2'd3}] <= sat32((xs + (64'sd1 <<< (cvt_pkg::CFG_FRAC - 1)))
                                         >>> cvt_pkg::CFG_FRAC);
            end
          end
          if (cnt_q == CNTW'(9)) begin
            for (int i = 0; i < 3; i++) begin
              m_q[i]     <= u_q[i];
              m_q[4 + i] <= 32'(nrm_q[1][i]);
              m_q[8 + i] <= 32'(nrm_q[0][i]);
            end
            cnt_q   <= '0;
            state_q <= ST_IDLE;
          end else begin
            cnt_q <= cnt_q + 1'b1;
          end
        end
        default: state_q <= ST_IDLE;
      endcase
    end
  end

  // point pipeline
  logic en;
  logic s1_v_q, s2_v_q, out_v_q;
  logic signed [31:0] p_q [4];
  logic signed [31:0] w2_q;
  logic signed [PW-1:0] pr_q [3][4];
  cvt_pkg::view_t view_q;

  assign en = !out_v_q || view_o.ready;
  assign point_i.ready = en && (state_q == ST_IDLE);
  assign view_o.valid = out_v_q;
  assign view_o.data = view_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q  <= 1'b0;
      s2_v_q  <= 1'b0;
      out_v_q <= 1'b0;
    end else if (en) begin
      s1_v_q  <= point_i.valid && point_i.ready;
      s2_v_q  <= s1_v_q;
      out_v_q <= s2_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    logic signed [63:0] mp;
    logic signed [SW-1:0] sum;
    if (en) begin
      p_q[0] <= point_i.data.point_x;
      p_q[1] <= point_i.data.point_y;
      p_q[2] <= point_i.data.point_z;
      p_q[3] <= point_i.data.point_w;
      w2_q   <= p_q[3];
      for (int r = 0; r < 3; r++) begin
        for (int c = 0; c < 4; c++) begin
          mp = m_q[r*4 + c] * p_q[c];
          pr_q[r][c] <= PW'((mp + (64'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
        end
      end
      sum = SW'(pr_q[0][0]) + SW'(pr_q[0][1]) + SW'(pr_q[0][2]) + SW'(pr_q[0][3]);
      view_q.view_x <= sat32(64'(sum));
      sum = SW'(pr_q[1][0]) + SW'(pr_q[1][1]) + SW'(pr_q[1][2]) + SW'(pr_q[1][3]);
      view_q.view_y <= sat32(64'(sum));
      sum = SW'(pr_q[2][0]) + SW'(pr_q[2][1]) + SW'(pr_q[2][2]) + SW'(pr_q[2][3]);
      view_q.view_z <= sat32(64'(sum));
      view_q.view_w <= w2_q;
    end
  end

endmodule
